/* rtl/rmsp_pkg.sv */
// ----------------------------------------------------------------------------
// rmsp_pkg: shared types and constants
// Register indexes, reset values and the structs that move between the
// parts of the RMSProp update block.
// ----------------------------------------------------------------------------
package rmsp_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_DECAY = 3'd0;
	localparam logic [2:0] REG_EPS   = 3'd1;
	localparam logic [2:0] REG_LR    = 3'd2;
	localparam logic [2:0] REG_COUNT = 3'd3;

	localparam logic [15:0] DECAY_RST = 16'd58982;
	localparam logic [31:0] EPS_RST   = 32'd4295;
	localparam logic [23:0] LR_RST    = 24'd167772;
	localparam logic [10:0] COUNT_RST = 11'd1024;

	localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
	localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;
	localparam int SQRT_STAGES = 32;
	localparam int QUOT_W      = 34;

	typedef struct packed {
		logic [15:0] decay;
		logic [31:0] eps;
		logic [23:0] lr;
		logic [10:0] count;
	} cfg_t;

	// item as it waits in the queue
	typedef struct packed {
		logic [9:0]  idx;
		logic [31:0] p;
		logic [31:0] g;
		logic        err;
	} item_t;

	// item side data carried down the back pipeline
	typedef struct packed {
		logic [9:0]  idx;
		logic [31:0] p;
		logic        neg;
		logic        err;
		logic [55:0] num;
	} tag_t;

endpackage

/* rtl/rmsp_front.sv */
// ----------------------------------------------------------------------------
// rmsp_front: accept and classify
// Takes items on start, flags out-of-range indexes and queues the items
// for the back pipeline.
// ----------------------------------------------------------------------------
module rmsp_front #(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              hold,
	output logic              busy,
	input  logic [9:0]        param_index,
	input  logic [31:0]       param_value,
	input  logic [31:0]       gradient_value,
	input  rmsp_pkg::cfg_t    cfg,
	input  logic              pop,
	output logic              head_valid,
	output rmsp_pkg::item_t   head
);
	import rmsp_pkg::*;

	item_t      q_mem [0:3];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       accept;
	logic       err;

	assign busy       = hold || (cnt_q == 3'd4);
	assign accept     = start && !busy;
	assign head_valid = (cnt_q != 3'd0);
	assign head       = q_mem[rd_ptr_q];
	assign err        = ({1'b0, param_index} >= cfg.count) ||
	                    ({1'b0, param_index} >= 11'(DEPTH));

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= '{idx: param_index, p: param_value,
			                     g: gradient_value, err: err};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(accept) - 3'(pop);
		end
	end

endmodule

/* rtl/rmsp_mean.sv */
// ----------------------------------------------------------------------------
// rmsp_mean: mean-square store and update
// Issues queued items, reads the running mean, forms
// decay*mean + (1-decay)*g*g and writes it back. Sets the store to 1.0 after reset.
// ----------------------------------------------------------------------------
module rmsp_mean #(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rmsp_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  rmsp_pkg::item_t   head,
	output logic              pop,
	output logic              clearing,
	output logic              v_out,
	output rmsp_pkg::tag_t    tag_out,
	output logic [63:0]       mean_out
);
	import rmsp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [63:0] mem [0:DEPTH-1];
	logic [63:0] rd_q;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic        v_s1, v_s2, v_s3, v_s4;
	item_t       it_s1;
	tag_t        tag_s2, tag_s3, tag_s4;
	logic [63:0] g2_s2;
	logic [47:0] mh_s2, ml_s2;
	logic [63:0] mterm_s3;
	logic [47:0] gh_s3;
	logic [48:0] gl_s3;
	logic [63:0] mean_s4;

	logic        hazard;
	logic        neg;
	logic [31:0] mag;
	logic [16:0] dm;
	logic [63:0] gterm, mnew;

	assign clearing = clr_q;

	// hold the head while an older item with the same index is still in flight
	assign hazard = !head.err && (
		(v_s1 && !it_s1.err  && it_s1.idx  == head.idx) ||
		(v_s2 && !tag_s2.err && tag_s2.idx == head.idx) ||
		(v_s3 && !tag_s3.err && tag_s3.idx == head.idx));
	assign pop = head_valid && !clr_q && !hazard;

	assign neg   = it_s1.g[31];
	assign mag   = neg ? (32'd0 - it_s1.g) : it_s1.g;
	assign dm    = 17'h10000 - {1'b0, cfg.decay};
	assign gterm = {gh_s3, 16'd0} + {31'd0, gl_s3[48:16]};
	assign mnew  = mterm_s3 + gterm;

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= ONE_Q32;
		end else if (v_s3 && !tag_s3.err) begin
			mem[tag_s3.idx[AW-1:0]] <= mnew;
		end
		if (pop) rd_q <= mem[head.idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
			end
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) it_s1 <= head;
		tag_s2   <= '{idx: it_s1.idx, p: it_s1.p, neg: neg, err: it_s1.err,
		             num: 56'(cfg.lr * mag)};
		g2_s2    <= 64'(mag * mag);
		mh_s2    <= 48'(rd_q[63:32] * cfg.decay);
		ml_s2    <= 48'(rd_q[31:0] * cfg.decay);
		tag_s3   <= tag_s2;
		mterm_s3 <= {mh_s2, 16'd0} + {32'd0, ml_s2[47:16]};
		gh_s3    <= 48'(g2_s2[63:32] * dm);
		gl_s3    <= 49'(g2_s2[31:0] * dm);
		tag_s4   <= tag_s3;
		mean_s4  <= mnew;
	end

	assign v_out    = v_s4;
	assign tag_out  = tag_s4;
	assign mean_out = mean_s4;

endmodule

/* rtl/rmsp_sqrt.sv */
// ----------------------------------------------------------------------------
// rmsp_sqrt: pipelined integer square root
// Adds epsilon with saturation, then resolves one root bit per stage.
// ----------------------------------------------------------------------------
module rmsp_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     eps,
	input  logic            v_in,
	input  rmsp_pkg::tag_t  tag_in,
	input  logic [63:0]     mean_in,
	output logic            v_out,
	output rmsp_pkg::tag_t  tag_out,
	output logic [31:0]     root
);
	import rmsp_pkg::*;

	logic        v_q   [0:SQRT_STAGES];
	tag_t        tag_q [0:SQRT_STAGES];
	logic [63:0] x_q   [0:SQRT_STAGES];
	logic [63:0] r_q   [0:SQRT_STAGES];
	logic [64:0] sum;

	assign sum = {1'b0, mean_in} + {33'd0, eps};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else         v_q[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= tag_in;
		x_q[0]   <= sum[64] ? '1 : sum[63:0];
		r_q[0]   <= '0;
	end

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		logic        ge;
		assign trial = r_q[i] + BIT;
		assign ge    = x_q[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else         v_q[i+1] <= v_q[i];
		end

		always_ff @(posedge clk) begin
			tag_q[i+1] <= tag_q[i];
			x_q[i+1]   <= ge ? (x_q[i] - trial) : x_q[i];
			r_q[i+1]   <= ge ? ((r_q[i] >> 1) + BIT) : (r_q[i] >> 1);
		end
	end

	assign v_out   = v_q[SQRT_STAGES];
	assign tag_out = tag_q[SQRT_STAGES];
	assign root    = r_q[SQRT_STAGES][31:0];

endmodule

/* rtl/rmsp_div.sv */
// ----------------------------------------------------------------------------
// rmsp_div: step division and parameter write-out
// Divides lr*|g| by root*2^8 one quotient bit per stage, clamps the step,
// applies it to the parameter with saturation and drives the result ports.
// ----------------------------------------------------------------------------
module rmsp_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_in,
	input  rmsp_pkg::tag_t  tag_in,
	input  logic [31:0]     root,
	output logic            done,
	output logic [9:0]      result_index,
	output logic [31:0]     new_param_value,
	output logic            index_error
);
	import rmsp_pkg::*;

	logic               v_q    [0:QUOT_W];
	tag_t               tag_q  [0:QUOT_W];
	logic [39:0]        d_q    [0:QUOT_W];
	logic [55:0]        rem_q  [0:QUOT_W];
	logic [QUOT_W-1:0]  quo_q  [0:QUOT_W];
	logic               ovf_q  [0:QUOT_W];
	logic               zero_q [0:QUOT_W];

	logic [39:0] dvs;
	logic [33:0] step;
	logic [35:0] np;
	tag_t        t;

	assign dvs = {root, 8'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else         v_q[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		tag_q[0]  <= tag_in;
		d_q[0]    <= dvs;
		rem_q[0]  <= tag_in.num;
		quo_q[0]  <= '0;
		ovf_q[0]  <= {18'd0, tag_in.num[55:34]} >= dvs;
		zero_q[0] <= (tag_in.num == 56'd0);
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
		localparam int K = QUOT_W - 1 - j;
		logic [73:0] dsh;
		logic        ge;
		assign dsh = {34'd0, d_q[j]} << K;
		assign ge  = {18'd0, rem_q[j]} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[j+1] <= 1'b0;
			else         v_q[j+1] <= v_q[j];
		end

		always_ff @(posedge clk) begin
			tag_q[j+1]  <= tag_q[j];
			d_q[j+1]    <= d_q[j];
			rem_q[j+1]  <= ge ? (rem_q[j] - dsh[55:0]) : rem_q[j];
			quo_q[j+1]  <= ge ? (quo_q[j] | (QUOT_W'(1) << K)) : quo_q[j];
			ovf_q[j+1]  <= ovf_q[j];
			zero_q[j+1] <= zero_q[j];
		end
	end

	assign t = tag_q[QUOT_W];

	always_comb begin
		if (ovf_q[QUOT_W]) begin
			step = zero_q[QUOT_W] ? 34'd0 : STEP_MAX;
		end else begin
			step = (quo_q[QUOT_W] > STEP_MAX) ? STEP_MAX : quo_q[QUOT_W];
		end
		if (t.neg) np = {{4{t.p[31]}}, t.p} + {2'b00, step};
		else       np = {{4{t.p[31]}}, t.p} - {2'b00, step};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_q[QUOT_W];
	end

	always_ff @(posedge clk) begin
		result_index <= t.idx;
		index_error  <= t.err;
		if (t.err) begin
			new_param_value <= t.p;
		end else if (!np[35] && (np[34:31] != 4'd0)) begin
			new_param_value <= 32'h7FFF_FFFF;
		end else if (np[35] && (np[34:31] != 4'hF)) begin
			new_param_value <= 32'h8000_0000;
		end else begin
			new_param_value <= np[31:0];
		end
	end

endmodule

/* rtl/rmsprop_param_update.sv */
// ----------------------------------------------------------------------------
// rmsprop_param_update: RMSProp parameter update, one parameter per item
// Keeps a running mean of squared gradients per parameter and returns
// param - lr*g/sqrt(mean+eps) in Q16.16, truncated and saturated.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     start & !busy        param_index, param_value, gradient_value
//  result    done (one cycle)     result_index, new_param_value, index_error
//  config    cfg_we               cfg_index, cfg_data
//
// An item may follow every cycle while busy is low; its result passes through
// the mean update, the 32-stage square root and the 34-stage divider. An item
// whose index matches one of the three items issued just before it waits in the
// queue until that read-modify-write of the mean store completes.
// After reset, busy stays high while the mean store is swept to 1.0, one
// entry per cycle, over N_PARAMS entries (at most 1024).
// The receiver cannot stall: results leave on done without backpressure.
//
module rmsprop_param_update #(
	parameter int N_PARAMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  param_index,
	input  logic [31:0] param_value,
	input  logic [31:0] gradient_value,
	output logic        done,
	output logic [9:0]  result_index,
	output logic [31:0] new_param_value,
	output logic        index_error,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rmsp_pkg::*;

	// store depth: indexes are 10 bits, so no more than 1024 entries are reachable
	localparam int DEPTH = (N_PARAMS < 1024) ? N_PARAMS : 1024;

	cfg_t        cfg_q;
	logic        clearing;
	logic        pop;
	logic        head_valid;
	item_t       head;
	logic        v_mean, v_sqrt;
	tag_t        tag_mean, tag_sqrt;
	logic [63:0] mean;
	logic [31:0] root;

	// configuration registers; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{decay: DECAY_RST, eps: EPS_RST, lr: LR_RST, count: COUNT_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECAY: cfg_q.decay <= cfg_data[15:0];
				REG_EPS:   cfg_q.eps   <= cfg_data;
				REG_LR:    cfg_q.lr    <= cfg_data[23:0];
				REG_COUNT: cfg_q.count <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// front: transfer and classify items, queue them for the back
	rmsp_front #(.DEPTH(DEPTH)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.hold           (clearing),
		.busy           (busy),
		.param_index    (param_index),
		.param_value    (param_value),
		.gradient_value (gradient_value),
		.cfg            (cfg_q),
		.pop            (pop),
		.head_valid     (head_valid),
		.head           (head)
	);

	// back, part one: issue, mean-square read-modify-write
	rmsp_mean #(.DEPTH(DEPTH)) u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.v_out      (v_mean),
		.tag_out    (tag_mean),
		.mean_out   (mean)
	);

	// back, part two: root of mean+eps
	rmsp_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.eps     (cfg_q.eps),
		.v_in    (v_mean),
		.tag_in  (tag_mean),
		.mean_in (mean),
		.v_out   (v_sqrt),
		.tag_out (tag_sqrt),
		.root    (root)
	);

	// back, part three: step, saturate, drive results
	rmsp_div u_div (
		.clk             (clk),
		.arst_n          (arst_n),
		.v_in            (v_sqrt),
		.tag_in          (tag_sqrt),
		.root            (root),
		.done            (done),
		.result_index    (result_index),
		.new_param_value (new_param_value),
		.index_error     (index_error)
	);

endmodule

/* rtl/rmsp_checker.sv */
// ----------------------------------------------------------------------------
// rmsp_checker: port-level checks
// Tracks outstanding items and the parameter count seen on the ports.
// ----------------------------------------------------------------------------
module rmsp_checker #(
	parameter int N_PARAMS = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [9:0]  result_index,
	input logic        index_error,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data
);
	import rmsp_pkg::*;

	logic [7:0]  out_q;
	logic [10:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q   <= '0;
			count_q <= COUNT_RST;
		end else begin
			out_q <= out_q + 8'(start && !busy) - 8'(done);
			if (cfg_we && cfg_index == REG_COUNT) count_q <= cfg_data[10:0];
		end
	end

	// no result without an outstanding transfer
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_q != 8'd0)
		else $error("result with no outstanding item");

	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_error |->
			({1'b0, result_index} >= count_q) || ({1'b0, result_index} >= 11'(N_PARAMS)))
		else $error("index error on a valid index");

	a_ok_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && !index_error |-> ({1'b0, result_index} < count_q))
		else $error("missing index error");

endmodule

bind rmsprop_param_update rmsp_checker #(.N_PARAMS(N_PARAMS)) u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_index (result_index),
	.index_error  (index_error),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);
